[hdl/md5_pkg.sv]
// md5 digest package: payload types, round constants and shift amounts
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       msg_end;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } out_word_t;

  typedef logic [511:0] block_t;

  typedef struct packed {
    logic   last_blk;
    block_t data;
  } blk_item_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam int          QDEPTH = 2;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

endpackage

[hdl/md5_message_digest_top.sv]
// md5 message digest top level
// a byte word is taken each cycle while no padding block is pending and the queue is not full
// each 64-byte block passes through the round engine as a load, 64 steps and an add
// the digest is written once the last block of a message has run through the round engine
// sustained rate is bound by the 64-step round loop; the queue lets new blocks fill meanwhile
// synchronous active-low reset restores the initial chaining words and empties all queues
module md5_message_digest_top import md5_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_word_t  in_word,
  output logic      out_empty,
  input  logic      out_pop,
  output out_word_t out_word
);

  logic      q_push, q_full, q_pop, q_empty;
  blk_item_t q_item, q_head;

  md5_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_word, .q_full, .q_push, .q_item
  );

  md5_queue u_queue (
    .clk, .rst_n, .q_push, .q_item, .q_full, .q_pop, .q_empty, .q_head
  );

  md5_back u_back (
    .clk, .rst_n, .q_empty, .q_head, .q_pop, .out_empty, .out_pop, .out_word
  );

endmodule

[hdl/md5_front.sv]
// md5 front end: packs bytes into blocks and builds the padding blocks
module md5_front import md5_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_word_t  in_word,
  input  logic      q_full,
  output logic      q_push,
  output blk_item_t q_item
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PAD  = 3'b010,
    ST_LEN  = 3'b100
  } fr_state_t;

  fr_state_t   st_r, st_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  block_t      blk_r, blk_nxt;
  block_t      blk_ins, pad_blk;
  logic [5:0]  used;
  logic [63:0] bit_len;

  assign used    = cnt_r[5:0];
  assign bit_len = {cnt_r, 3'b000};
  assign in_full = (st_r != ST_IDLE) || q_full;

  always_comb begin
    blk_ins = blk_r;
    blk_ins[8*used +: 8] = in_word.data_byte;
    for (int i = 0; i < 64; i++) begin
      if (st_r == ST_PAD && 6'(i) < used) begin
        pad_blk[8*i +: 8] = blk_r[8*i +: 8];
      end else if (st_r == ST_PAD && 6'(i) == used) begin
        pad_blk[8*i +: 8] = 8'h80;
      end else begin
        pad_blk[8*i +: 8] = 8'h00;
      end
    end
    if (st_r == ST_LEN || used < 6'd56) begin
      pad_blk[511:448] = bit_len;
    end
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    blk_nxt = blk_r;
    q_push = 1'b0;
    q_item = '{last_blk: 1'b0, data: blk_ins};
    case (st_r)
      ST_IDLE: begin
        if (in_push && !in_full) begin
          if (in_word.byte_valid) begin
            blk_nxt = blk_ins;
            cnt_nxt = cnt_r + 61'd1;
            if (used == 6'd63) begin
              q_push = 1'b1;
            end
          end
          if (in_word.msg_end) begin
            st_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        q_item = '{last_blk: (used < 6'd56), data: pad_blk};
        if (!q_full) begin
          q_push = 1'b1;
          if (used < 6'd56) begin
            st_nxt = ST_IDLE;
            cnt_nxt = '0;
          end else begin
            st_nxt = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        q_item = '{last_blk: 1'b1, data: pad_blk};
        if (!q_full) begin
          q_push = 1'b1;
          st_nxt = ST_IDLE;
          cnt_nxt = '0;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    blk_r <= blk_nxt;
  end

endmodule

[hdl/md5_queue.sv]
// md5 block queue between front end and round engine
module md5_queue import md5_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_push,
  input  blk_item_t q_item,
  output logic      q_full,
  input  logic      q_pop,
  output logic      q_empty,
  output blk_item_t q_head
);

  blk_item_t  mem_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == 2'(QDEPTH));
  assign q_empty = (cnt_r == 2'd0);
  assign q_head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (q_push && !q_full) begin
      wr_ptr_nxt = ~wr_ptr_r;
      cnt_nxt = cnt_nxt + 2'd1;
    end
    if (q_pop && !q_empty) begin
      rd_ptr_nxt = ~rd_ptr_r;
      cnt_nxt = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (q_push && !q_full) begin
      mem_r[wr_ptr_r] <= q_item;
    end
  end

endmodule

[hdl/md5_back.sv]
// md5 round engine: one step per cycle, chaining update and digest register
module md5_back import md5_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  blk_item_t q_head,
  output logic      q_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output out_word_t out_word
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_RUN  = 3'b010,
    BK_ADD  = 3'b100
  } bk_state_t;

  bk_state_t   st_r, st_nxt;
  logic [5:0]  step_r, step_nxt;
  logic        last_r, last_nxt;
  block_t      w_r, w_nxt;
  logic [31:0] a_r, b_r, c_r, d_r, a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0] ca_r, cb_r, cc_r, cd_r, ca_nxt, cb_nxt, cc_nxt, cd_nxt;
  out_word_t   out_r, out_nxt;
  logic        oval_r, oval_nxt;
  logic [31:0] f, tmp, rotv;
  logic [63:0] rot64;
  logic [3:0]  g;
  logic [1:0]  rnd;

  assign rnd       = step_r[5:4];
  assign out_empty = !oval_r;
  assign out_word  = out_r;
  assign q_pop     = (st_r == BK_IDLE) && !q_empty && (!q_head.last_blk || !oval_r);

  always_comb begin
    case (rnd)
      2'd0: begin
        f = (b_r & c_r) | (~b_r & d_r);
        g = step_r[3:0];
      end
      2'd1: begin
        f = (b_r & d_r) | (c_r & ~d_r);
        g = 4'(5 * step_r + 1);
      end
      2'd2: begin
        f = b_r ^ c_r ^ d_r;
        g = 4'(3 * step_r + 5);
      end
      default: begin
        f = c_r ^ (b_r | ~d_r);
        g = 4'(7 * step_r);
      end
    endcase
    tmp = a_r + f + ROUND_K[step_r] + w_r[32*g +: 32];
    rot64 = {tmp, tmp} << ROT_S[{rnd, step_r[1:0]}];
    rotv = rot64[63:32];
  end

  always_comb begin
    st_nxt = st_r;
    step_nxt = step_r;
    last_nxt = last_r;
    w_nxt = w_r;
    {a_nxt, b_nxt, c_nxt, d_nxt} = {a_r, b_r, c_r, d_r};
    {ca_nxt, cb_nxt, cc_nxt, cd_nxt} = {ca_r, cb_r, cc_r, cd_r};
    out_nxt = out_r;
    oval_nxt = oval_r;
    if (out_pop && oval_r) begin
      oval_nxt = 1'b0;
    end
    case (st_r)
      BK_IDLE: begin
        if (q_pop) begin
          st_nxt = BK_RUN;
          step_nxt = '0;
          last_nxt = q_head.last_blk;
          w_nxt = q_head.data;
          {a_nxt, b_nxt, c_nxt, d_nxt} = {ca_r, cb_r, cc_r, cd_r};
        end
      end
      BK_RUN: begin
        a_nxt = d_r;
        d_nxt = c_r;
        c_nxt = b_r;
        b_nxt = b_r + rotv;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd63) begin
          st_nxt = BK_ADD;
        end
      end
      BK_ADD: begin
        st_nxt = BK_IDLE;
        if (last_r) begin
          out_nxt = '{digest_a: ca_r + a_r, digest_b: cb_r + b_r,
                      digest_c: cc_r + c_r, digest_d: cd_r + d_r};
          oval_nxt = 1'b1;
          {ca_nxt, cb_nxt, cc_nxt, cd_nxt} = {INIT_A, INIT_B, INIT_C, INIT_D};
        end else begin
          ca_nxt = ca_r + a_r;
          cb_nxt = cb_r + b_r;
          cc_nxt = cc_r + c_r;
          cd_nxt = cd_r + d_r;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      oval_r <= 1'b0;
      {ca_r, cb_r, cc_r, cd_r} <= {INIT_A, INIT_B, INIT_C, INIT_D};
    end else begin
      st_r <= st_nxt;
      oval_r <= oval_nxt;
      {ca_r, cb_r, cc_r, cd_r} <= {ca_nxt, cb_nxt, cc_nxt, cd_nxt};
    end
    step_r <= step_nxt;
    last_r <= last_nxt;
    w_r <= w_nxt;
    {a_r, b_r, c_r, d_r} <= {a_nxt, b_nxt, c_nxt, d_nxt};
    out_r <= out_nxt;
  end

endmodule

[hdl/md5_checker.sv]
// md5 port checker and its bind to the top level
module md5_checker import md5_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input logic      in_full,
  input in_word_t  in_word,
  input logic      out_empty,
  input logic      out_pop,
  input out_word_t out_word
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word)))
    else $error("waiting digest changed or vanished");

  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_word.msg_end) |=> in_full)
    else $error("input taken during padding");

endmodule

bind md5_message_digest_top md5_checker u_md5_checker (
  .clk, .rst_n, .in_push, .in_full, .in_word, .out_empty, .out_pop, .out_word
);
